// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the hex record loader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define HRL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hex record loader check failed");

// Clocked assertion that also holds across reset.
`define HRL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hex record loader check failed");

`endif

// ===== sv/hrl_pkg.sv =====
// Types, constants and the hex digit decoder of the hex record loader.
package hrl_pkg;

  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Record parsing phases, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT  = 7'b000_0001,
    PH_COUNT = 7'b000_0010,
    PH_ADDR  = 7'b000_0100,
    PH_TYPE  = 7'b000_1000,
    PH_DATA  = 7'b001_0000,
    PH_CSUM  = 7'b010_0000,
    PH_HALT  = 7'b100_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  value;
  } hex_digit_t;

  // Accepts 0-9, A-F and a-f.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.value = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== sv/hrl_step.sv =====
// Record parser: phase and field counters, advanced by one character per step.
module hrl_step import hrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] char_in,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [1:0] digit_index_r, digit_index_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;

  hex_digit_t hd;
  logic [7:0] byte_val;
  logic [7:0] bytes_dec;

  assign hd        = hex_decode(char_in);
  assign byte_val  = {high_nibble_r, hd.value};
  assign bytes_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    digit_index_nxt = digit_index_r;
    high_nibble_nxt = high_nibble_r;
    bytes_left_nxt  = bytes_left_r;
    res_valid       = 1'b0;
    res.kind        = KIND_DATA;
    res.data_byte   = 8'd0;
    if (step_en) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (char_in == COLON_CHAR) begin
            phase_nxt       = PH_COUNT;
            digit_index_nxt = 2'd0;
          end
        end
        PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
          if (!hd.ok) begin
            phase_nxt = PH_HALT;
            res_valid = 1'b1;
            res.kind  = KIND_ERR;
          end else if (phase_r == PH_ADDR) begin
            // Four address digits, discarded.
            if (digit_index_r == 2'd3) begin
              phase_nxt       = PH_TYPE;
              digit_index_nxt = 2'd0;
            end else begin
              digit_index_nxt = digit_index_r + 2'd1;
            end
          end else if (digit_index_r == 2'd0) begin
            high_nibble_nxt = hd.value;
            digit_index_nxt = 2'd1;
          end else begin
            digit_index_nxt = 2'd0;
            if (phase_r == PH_COUNT) begin
              if (byte_val == 8'd0) begin
                phase_nxt = PH_HALT;
                res_valid = 1'b1;
                res.kind  = KIND_END;
              end else begin
                bytes_left_nxt = byte_val;
                phase_nxt      = PH_ADDR;
              end
            end else if (phase_r == PH_TYPE) begin
              phase_nxt = PH_DATA;
            end else if (phase_r == PH_DATA) begin
              bytes_left_nxt = bytes_dec;
              if (bytes_dec == 8'd0) begin
                phase_nxt = PH_CSUM;
              end
              res_valid     = 1'b1;
              res.data_byte = byte_val;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        end
        default: begin
          // Halted: characters are dropped until reset.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      digit_index_r <= 2'd0;
      high_nibble_r <= 4'd0;
      bytes_left_r  <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      digit_index_r <= digit_index_nxt;
      high_nibble_r <= high_nibble_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

endmodule

// ===== sv/hrl_out_stage.sv =====
// Result register towards the output stream, with its load/hold control.
module hrl_out_stage import hrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    load_res,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= load_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.data_byte;
  assign out_tuser  = res_r.kind;

endmodule

// ===== sv/hex_record_loader.sv =====
// Top level of the hex record loader: input register, record parser and result register.
//
// The hex record loader takes a hex record text stream one character per item and
// gives out the decoded data bytes. It skips anything up to a colon, reads the
// two-digit byte count, discards the four address digits and two type digits,
// then emits one result item per data byte and reads past the two checksum digits
// without checking them, before hunting for the next colon. A byte count of zero
// gives an end item and halts the block; a character that is not a hex digit
// (0-9, A-F, a-f) in any digit field gives an error item and halts it at once.
// Once halted, every character is accepted and dropped until reset. Result items
// carry the kind on out_tuser (data, end or error) and the byte on out_tdata,
// which is zero for end and error items.
// Throughput is one character per clock cycle while the output is not stalled. An accepted
// character passes the input register, then the parser logic, then the result register
// before its result item appears. A stalled output holds the
// result register and then the input register; a new character is still taken
// while a finished result waits, as long as the input register is free.

module hex_record_loader import hrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [1:0] out_tuser   // [1:0] kind
);

  // Input register holding one character.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;

  logic       can_load;
  logic       step_en;
  logic       res_valid;
  result_t    res;
  logic       in_accept;

  // The parser steps when a character is held and the result register can take
  // whatever it produces.
  assign step_en   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_char_r <= in_tdata;
    end
  end

  hrl_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .char_in   (in_char_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hrl_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en && res_valid),
    .load_res   (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/hrl_checker.sv =====
// Port-level checks on the hex record loader's result stream, bound to the top level.
`include "assert_macros.svh"

module hrl_checker import hrl_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata == in_tdata);

  `HRL_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `HRL_ASSERT(a_kind_legal, clk, rst_n, out_tvalid |-> out_tuser == KIND_DATA || out_tuser == KIND_END || out_tuser == KIND_ERR)
  `HRL_ASSERT(a_ctrl_zero, clk, rst_n, out_tvalid && out_tuser != KIND_DATA |-> out_tdata == 8'd0)
  `HRL_ASSERT(a_halt_quiet, clk, rst_n, out_tvalid && out_tready && out_tuser != KIND_DATA |=> !out_tvalid)
  `HRL_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) && !in_seen |-> !out_tvalid)

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/hex_record_checker.sv =====
`timescale 1ns / 100ps
// Watches both streams of the hex record loader, decodes the text itself and checks each result.
module hex_record_checker import hrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] data_byte
  input  logic [1:0] out_tuser,  // [1:0] kind
  output int         mismatch_count,
  output int         decoded_pending,
  output int         results_seen
);

  phase_t     phase;
  logic [1:0] digit_pos;
  logic [3:0] upper_nibble;
  logic [7:0] bytes_to_come;
  result_t    decoded_results[$];

  // Returns {valid, value}; letters are folded to lower case before the range test.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] folded;
    logic [7:0] offset;
    folded = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) begin
      offset = c - 8'h30;
      return {1'b1, offset[3:0]};
    end
    if (folded >= 8'h61 && folded <= 8'h66) begin
      offset = folded - 8'h57;
      return {1'b1, offset[3:0]};
    end
    return 5'd0;
  endfunction

  task automatic add_result(input kind_t k, input logic [7:0] b);
    result_t r;
    r.kind      = k;
    r.data_byte = b;
    decoded_results.push_back(r);
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [4:0] d;
    logic [7:0] byte_val;
    case (phase)
      PH_HUNT: begin
        if (c == COLON_CHAR) begin
          phase     = PH_COUNT;
          digit_pos = 2'd0;
        end
      end
      PH_HALT: begin
      end
      default: begin
        d = digit_of(c);
        if (!d[4]) begin
          phase = PH_HALT;
          add_result(KIND_ERR, 8'h00);
        end else if (phase == PH_ADDR) begin
          if (digit_pos == 2'd3) begin
            phase     = PH_TYPE;
            digit_pos = 2'd0;
          end else begin
            digit_pos = digit_pos + 2'd1;
          end
        end else if (digit_pos == 2'd0) begin
          upper_nibble = d[3:0];
          digit_pos    = 2'd1;
        end else begin
          digit_pos = 2'd0;
          byte_val  = {upper_nibble, d[3:0]};
          case (phase)
            PH_COUNT: begin
              if (byte_val == 8'h00) begin
                phase = PH_HALT;
                add_result(KIND_END, 8'h00);
              end else begin
                bytes_to_come = byte_val;
                phase         = PH_ADDR;
              end
            end
            PH_TYPE: phase = PH_DATA;
            PH_DATA: begin
              bytes_to_come = bytes_to_come - 8'd1;
              if (bytes_to_come == 8'h00) phase = PH_CSUM;
              add_result(KIND_DATA, byte_val);
            end
            default: phase = PH_HUNT;
          endcase
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase         = PH_HUNT;
      digit_pos     = 2'd0;
      upper_nibble  = 4'd0;
      bytes_to_come = 8'd0;
      decoded_results.delete();
    end else begin
      // Results leave only after the input and result registers, so compare before predicting.
      if (out_tvalid && out_tready) begin
        if (decoded_results.size() == 0) begin
          $error("unexpected result item: kind %0d, data_byte 0x%02h", out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = decoded_results.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
            mismatch_count++;
          end
          if (out_tdata !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, out_tdata);
            mismatch_count++;
          end
          results_seen++;
        end
      end
      if (in_tvalid && in_tready) decode_char(in_tdata);
    end
    decoded_pending = decoded_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the bench: clock, reset, hex record stimulus, flow control and the verdict.
module testbench;
  import hrl_pkg::*;

  localparam int CHAR_TARGET = 600;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int GAP_PCT     = 36;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  int    mismatch_count;
  int    decoded_pending;
  int    results_seen;
  int    chars_sent   = 0;
  int    records_sent = 0;
  int    cycle_count  = 0;
  // While set, neither side inserts idle cycles.
  bit    steady       = 1'b0;
  string ending       = "nothing";

  always #10 clk = ~clk;

  hex_record_loader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  hex_record_checker decode_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .decoded_pending (decoded_pending),
    .results_seen    (results_seen)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[hex_record_loader] ERROR");
      $finish;
    end
  end

  // The receiver drops tready at random, except in the steady window. Early in the run it
  // holds off completely for a long stretch, so that both internal registers fill and the
  // block has to stall the sender, who keeps offering characters throughout.
  initial begin : sink
    int sink_cycles;
    sink_cycles = 0;
    forever begin
      @(negedge clk);
      sink_cycles++;
      if (sink_cycles >= 200 && sink_cycles < 320) begin
        out_tready = 1'b0;
      end else if (steady) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(0, 99) >= GAP_PCT);
      end
    end
  end

  // Offers one character and returns at the falling edge after it has been accepted.
  // tvalid stays high into the next call, which lowers it only if it decides to idle.
  task automatic send_char(input logic [7:0] c);
    while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
    steady = (chars_sent >= 300 && chars_sent < 400);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Letter digits come out in upper or lower case at random.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    send_char(hex_char(b[7:4]));
    send_char(hex_char(b[3:0]));
  endtask

  // Filler between records: any byte value except a colon.
  task automatic send_noise(input int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == COLON_CHAR);
      send_char(c);
    end
  endtask

  task automatic send_record(input logic [7:0] count);
    send_char(COLON_CHAR);
    send_byte(count);
    repeat (3) send_byte(8'($urandom_range(0, 255)));   // address and record type
    repeat (count) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));              // checksum, never checked
    records_sent++;
  endtask

  // Sends a record up to a character that is not a hex digit, placed in the given field.
  task automatic send_broken_record(input int field);
    logic [7:0] digits[$];
    logic [7:0] count;
    logic [7:0] bad;
    logic [7:0] folded;
    int         first;
    int         span;
    int         cut;
    int         i;
    count = 8'($urandom_range(1, 4));
    digits.push_back(hex_char(count[7:4]));
    digits.push_back(hex_char(count[3:0]));
    repeat (2 * (4 + count)) digits.push_back(hex_char(4'($urandom_range(0, 15))));
    case (field)
      1:       begin first = 0; span = 2; ending = "bad digit in the count"; end
      2:       begin first = 2; span = 4; ending = "bad digit in the address"; end
      3:       begin first = 6; span = 2; ending = "bad digit in the type"; end
      4:       begin first = 8; span = 2 * count; ending = "bad digit in the data"; end
      default: begin first = 8 + 2 * count; span = 2; ending = "bad digit in the checksum"; end
    endcase
    cut = first + $urandom_range(0, span - 1);
    do begin
      bad    = 8'($urandom_range(0, 255));
      folded = bad | 8'h20;
    end while ((bad >= 8'h30 && bad <= 8'h39) || (folded >= 8'h61 && folded <= 8'h66));
    send_char(COLON_CHAR);
    for (i = 0; i < cut; i++) send_char(digits[i]);
    send_char(bad);
    records_sent++;
  endtask

  initial begin : stimulus
    logic [7:0] count;
    int         finish_kind;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: mixed-case digits, data bytes at both extremes, then filler with all-zero,
    // all-one and line feed characters before the next colon.
    send_text(":02aB9f0000fFCd");
    records_sent++;
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h0A);

    // Random well-formed records with filler between them; now and then a long one.
    while (chars_sent < CHAR_TARGET) begin
      send_noise($urandom_range(0, 3));
      if ($urandom_range(0, 24) == 0) count = 8'($urandom_range(9, 255));
      else count = 8'($urandom_range(1, 8));
      send_record(count);
    end

    // The block halts for good on an end record or a bad digit, so exactly one of them
    // closes the run. Everything after it, records included, must be dropped silently.
    finish_kind = $urandom_range(0, 5);
    if (finish_kind == 0) begin
      send_text(":00");
      records_sent++;
      ending = "an end record";
    end else begin
      send_broken_record(finish_kind);
    end
    send_noise(6);
    send_record(8'($urandom_range(1, 3)));
    send_text(":00000001FF");
    in_tvalid = 1'b0;

    while (decoded_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d characters in %0d records, closed by %s.",
             chars_sent, records_sent, ending);
    $display("%0d result items compared, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0 && decoded_pending == 0) begin
      $display("[hex_record_loader] OK");
    end else begin
      $display("[hex_record_loader] ERROR");
    end
    $finish;
  end

endmodule
